FILE: src/bq3_pkg.sv
// shared constants, types and state encodings for the three-lane biquad low-pass
package bq3_pkg;

  localparam int LANES          = 3;
  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 16;
  localparam int STATE_BITS_DEF = 40;
  localparam int CFG_DATA_W     = COEF_FRAC_BITS + 2;
  localparam int CFG_IDX_W      = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B0     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A1     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A2     = 2'd3;

  // input mode codes
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_PRESET = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic                             enable;
    logic [COEF_FRAC_BITS-1:0]        b0;
    logic signed [COEF_FRAC_BITS+1:0] a1;
    logic [COEF_FRAC_BITS-1:0]        a2;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic mode;
    logic on;
  } lane_ctl_t;

  typedef enum logic [2:0] {
    LS_IDLE,
    LS_MUL,
    LS_SUM,
    LS_FB,
    LS_UPD
  } lane_st_t;

  typedef enum logic [1:0] {
    TS_IDLE,
    TS_BUSY,
    TS_HOLD
  } top_st_t;

endpackage

FILE: src/bq3_in_if.sv
// input channel: valid/ready handshake with mode, lane select and three samples
interface bq3_in_if;
  import bq3_pkg::*;

  logic               valid;
  logic               ready;
  logic               mode;
  logic [LANES-1:0]   lane_enable;
  sample_t            sample_a;
  sample_t            sample_b;
  sample_t            sample_c;

  modport source (output valid, mode, lane_enable, sample_a, sample_b, sample_c,
                  input ready);
  modport sink   (input valid, mode, lane_enable, sample_a, sample_b, sample_c,
                  output ready);
endinterface

FILE: src/bq3_out_if.sv
// result channel: valid/ready handshake with three filtered samples and lane flags
interface bq3_out_if;
  import bq3_pkg::*;

  logic               valid;
  logic               ready;
  sample_t            filtered_a;
  sample_t            filtered_b;
  sample_t            filtered_c;
  logic [LANES-1:0]   lanes_valid;

  modport source (output valid, filtered_a, filtered_b, filtered_c, lanes_valid,
                  input ready);
  modport sink   (input valid, filtered_a, filtered_b, filtered_c, lanes_valid,
                  output ready);
endinterface

FILE: src/bq3_lane.sv
// one filter lane: transposed direct form II biquad with its own two delays
module bq3_lane #(
  parameter int STATE_BITS = bq3_pkg::STATE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bq3_pkg::lane_ctl_t ctl,
  input  bq3_pkg::sample_t   x,
  input  bq3_pkg::cfg_t      cfg,
  output bq3_pkg::sample_t   y,
  output logic               done
);
  import bq3_pkg::*;

  localparam int F   = COEF_FRAC_BITS;
  localparam int SB  = SAMPLE_BITS;
  localparam int ST  = STATE_BITS;
  localparam int CW  = F + 2;          // signed coefficient width
  localparam int PW  = SB + CW;        // coefficient times sample
  localparam int PRW = ST + CW;        // coefficient times full output
  localparam int WW  = ST + F + 4;     // working width for sums
  localparam logic signed [WW-1:0] RND = WW'(1) <<< (F - 1);

  lane_st_t state_r, state_nxt;

  logic              mode_r, on_r;
  sample_t           x_r;
  logic signed [PW-1:0]  bx_r, pd1_r, pd2_r;
  logic signed [ST-1:0]  yf_r, d1_r, d2_r;
  logic signed [PRW-1:0] p1_r, p2_r;
  sample_t           y_r;

  logic signed [PW-1:0]  bx_nxt, pd1_nxt, pd2_nxt;
  logic signed [ST-1:0]  yf_nxt, d1_nxt, d2_nxt;
  logic signed [PRW-1:0] p1_nxt, p2_nxt;
  sample_t           y_nxt;
  logic              d_we;

  logic signed [CW-1:0] b0_s, a1_s, a2_s, g1_s, g2_s;
  logic signed [WW-1:0] yrnd, r1, r2, n1, n2, t1, t2;

  // saturate a working value to the delay width
  function automatic logic signed [ST-1:0] sat_st(input logic signed [WW-1:0] v);
    if ((v[WW-1:ST-1] == '0) || (v[WW-1:ST-1] == '1)) begin
      return v[ST-1:0];
    end else if (v[WW-1]) begin
      return {1'b1, {(ST-1){1'b0}}};
    end else begin
      return {1'b0, {(ST-1){1'b1}}};
    end
  endfunction

  // saturate a working value to the sample width
  function automatic sample_t sat_smp(input logic signed [WW-1:0] v);
    if ((v[WW-1:SB-1] == '0) || (v[WW-1:SB-1] == '1)) begin
      return v[SB-1:0];
    end else if (v[WW-1]) begin
      return {1'b1, {(SB-1){1'b0}}};
    end else begin
      return {1'b0, {(SB-1){1'b1}}};
    end
  endfunction

  // coefficient views
  assign b0_s = signed'({2'b00, cfg.b0});
  assign a1_s = cfg.a1;
  assign a2_s = signed'({2'b00, cfg.a2});
  assign g1_s = signed'({2'b01, F'(0)}) - b0_s;
  assign g2_s = b0_s - a2_s;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      LS_IDLE: if (ctl.start) state_nxt = LS_MUL;
      LS_MUL:  state_nxt = LS_SUM;
      LS_SUM:  state_nxt = (mode_r == MODE_PRESET) ? LS_IDLE : LS_FB;
      LS_FB:   state_nxt = LS_UPD;
      LS_UPD:  state_nxt = LS_IDLE;
      default: state_nxt = LS_IDLE;
    endcase
  end

  // rounding and feedback terms
  always_comb begin
    yrnd = (WW'(yf_r) + RND) >>> F;
    t1   = WW'(p1_r) + RND;
    t2   = WW'(p2_r) + RND;
    r1   = t1 >>> F;
    r2   = t2 >>> F;
    n1   = (WW'(bx_r) <<< 1) + WW'(d2_r) - r1;
    n2   = WW'(bx_r) - r2;
  end

  // datapath outputs per state
  always_comb begin
    bx_nxt  = PW'(b0_s) * PW'(x_r);
    pd1_nxt = PW'(g1_s) * PW'(x_r);
    pd2_nxt = PW'(g2_s) * PW'(x_r);
    yf_nxt  = sat_st(WW'(bx_r) + WW'(d1_r));
    p1_nxt  = PRW'(a1_s) * PRW'(yf_r);
    p2_nxt  = PRW'(a2_s) * PRW'(yf_r);
    y_nxt   = '0;
    if (on_r) begin
      y_nxt = cfg.enable ? sat_smp(yrnd) : x_r;
    end
    d_we    = 1'b0;
    d1_nxt  = d1_r;
    d2_nxt  = d2_r;
    done    = 1'b0;
    case (state_r)
      LS_SUM: begin
        if (mode_r == MODE_PRESET) begin
          done = 1'b1;
          d_we = on_r;
          if (cfg.enable) begin
            d1_nxt = sat_st(WW'(pd1_r));
            d2_nxt = sat_st(WW'(pd2_r));
          end else begin
            d1_nxt = '0;
            d2_nxt = '0;
          end
        end
      end
      LS_UPD: begin
        done   = 1'b1;
        d_we   = on_r && cfg.enable;
        d1_nxt = sat_st(n1);
        d2_nxt = sat_st(n2);
      end
      default: begin
        done = 1'b0;
      end
    endcase
  end

  // control and delay registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LS_IDLE;
      d1_r    <= '0;
      d2_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (d_we) begin
        d1_r <= d1_nxt;
        d2_r <= d2_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == LS_IDLE && ctl.start) begin
      mode_r <= ctl.mode;
      on_r   <= ctl.on;
      x_r    <= x;
    end
    if (state_r == LS_MUL) begin
      bx_r  <= bx_nxt;
      pd1_r <= pd1_nxt;
      pd2_r <= pd2_nxt;
    end
    if (state_r == LS_SUM) begin
      yf_r <= yf_nxt;
    end
    if (state_r == LS_FB) begin
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
      y_r  <= y_nxt;
    end
  end

  assign y = y_r;

endmodule

FILE: src/bq3_merge.sv
// merging stage: gathers the lane outputs into the result register
module bq3_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  bq3_pkg::sample_t    ys [bq3_pkg::LANES],
  input  logic [bq3_pkg::LANES-1:0] sel,
  output logic                free,
  bq3_out_if.source           out_ch
);
  import bq3_pkg::*;

  logic             valid_r, valid_nxt;
  sample_t          fa_r, fb_r, fc_r;
  logic [LANES-1:0] lanes_r;

  assign free = !valid_r || out_ch.ready;

  // result valid flag
  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      fa_r    <= ys[0];
      fb_r    <= ys[1];
      fc_r    <= ys[2];
      lanes_r <= sel;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.filtered_a  = fa_r;
  assign out_ch.filtered_b  = fb_r;
  assign out_ch.filtered_c  = fc_r;
  assign out_ch.lanes_valid = lanes_r;

endmodule

FILE: src/butterworth_biquad_lowpass_3ch.sv
// top level: three-lane second-order butterworth low-pass biquad
// a sample transaction runs through the four-step multiply/accumulate sequence
// of the lanes (multiply, sum, feedback, update), a preset stops after the sum;
// a new transaction is taken only once the last one is done and, for a sample,
// its result is in the output register, where it waits while the next one runs
// reset (synchronous, rst_n low) clears all delays and loads the register defaults
module butterworth_biquad_lowpass_3ch #(
  parameter int STATE_BITS = bq3_pkg::STATE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bq3_in_if.sink                         in_ch,
  bq3_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [bq3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bq3_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bq3_pkg::*;

  top_st_t          state_r, state_nxt;
  cfg_t             cfg_r;
  logic             mode_r;
  logic [LANES-1:0] sel_r;
  logic             in_fire, load, free, all_done;
  logic [LANES-1:0] done_vec;
  sample_t          xs [LANES];
  sample_t          ys [LANES];
  lane_ctl_t        ctl [LANES];

  assign in_fire = in_ch.valid && in_ch.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable <= 1'b0;
      cfg_r.b0     <= '1;
      cfg_r.a1     <= '0;
      cfg_r.a2     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE: cfg_r.enable <= cfg_wdata[0];
        REG_B0:     cfg_r.b0     <= cfg_wdata[COEF_FRAC_BITS-1:0];
        REG_A1:     cfg_r.a1     <= cfg_wdata[COEF_FRAC_BITS+1:0];
        REG_A2:     cfg_r.a2     <= cfg_wdata[COEF_FRAC_BITS-1:0];
        default:    cfg_r        <= cfg_r;
      endcase
    end
  end

  // transaction fields kept for the merge
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r <= in_ch.mode;
      sel_r  <= in_ch.lane_enable;
    end
  end

  assign xs[0] = in_ch.sample_a;
  assign xs[1] = in_ch.sample_b;
  assign xs[2] = in_ch.sample_c;

  // lanes
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    assign ctl[i] = '{start: in_fire, mode: in_ch.mode, on: in_ch.lane_enable[i]};
    bq3_lane #(.STATE_BITS(STATE_BITS)) u_lane (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl  (ctl[i]),
      .x    (xs[i]),
      .cfg  (cfg_r),
      .y    (ys[i]),
      .done (done_vec[i])
    );
  end

  assign all_done = &done_vec;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      TS_IDLE: if (in_fire) state_nxt = TS_BUSY;
      TS_BUSY: begin
        if (all_done) begin
          if (mode_r == MODE_PRESET || free) begin
            state_nxt = TS_IDLE;
          end else begin
            state_nxt = TS_HOLD;
          end
        end
      end
      TS_HOLD: if (free) state_nxt = TS_IDLE;
      default: state_nxt = TS_IDLE;
    endcase
  end

  // outputs per state
  always_comb begin
    in_ch.ready = 1'b0;
    load        = 1'b0;
    case (state_r)
      TS_IDLE: in_ch.ready = 1'b1;
      TS_BUSY: load = all_done && (mode_r == MODE_SAMPLE) && free;
      TS_HOLD: load = free;
      default: load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  bq3_merge u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (load),
    .ys    (ys),
    .sel   (sel_r),
    .free  (free),
    .out_ch(out_ch)
  );

  // lanes run in lockstep
  a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (done_vec == '0) || (done_vec == '1))
    else $error("lanes out of step");

  // no new transaction right after one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("input taken while busy");

  // result register is only loaded when it can take the result
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("result overwritten");

  // a preset transaction produces no result
  a_preset_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == TS_BUSY && all_done && mode_r == MODE_PRESET) |-> !load)
    else $error("preset produced a result");

endmodule
